// ===== sv/sfpp_pkg.sv =====
// Shared constants and types for the slice farthest point pair unit.
// No dependencies.
package sfpp_pkg;
    localparam int MAX_POINTS_D = 1024;
    localparam int COORD_BITS_D = 16;
    localparam logic signed [15:0] Z_LOW_RST = 16'sd500;
    localparam logic signed [15:0] Z_HIGH_RST = 16'sd520;
    localparam logic CFG_Z_LOW = 1'b0;
    localparam logic CFG_Z_HIGH = 1'b1;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic               found;
        logic [9:0]         first_index;
        logic [9:0]         second_index;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic [16:0]        distance;
        logic               overflow;
        logic [10:0]        kept_count;
    } t_pair;
endpackage

// ===== sv/sfpp_if.sv =====
// Valid/ready channel carrying one item payload.
// Payload type is a parameter of the interface.
interface sfpp_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sfpp_cell.sv =====
// One cell of the search chain: squared distance term of one axis.
// Uses sfpp_pkg; the three cells pass the partial sum down the chain.
module sfpp_cell import sfpp_pkg::*; #(
    parameter int CB = COORD_BITS_D,
    parameter int SW = 2 * CB + 3
) (
    input  logic                 i_clk,
    input  logic signed [CB-1:0] i_a,
    input  logic signed [CB-1:0] i_b,
    input  logic [SW-1:0]        i_sum,
    output logic [SW-1:0]        o_sum
);
    logic signed [CB:0] w_d;
    logic [CB:0]        w_u;
    logic [SW-1:0]      r_sum;
    assign w_d = CB'(0) + i_a - i_b;
    assign w_u = w_d[CB] ? (CB+1)'(-w_d) : w_d;
    always_ff @(posedge i_clk) begin
        r_sum <= i_sum + SW'(w_u * w_u);
    end
    assign o_sum = r_sum;
endmodule

// ===== sv/slice_farthest_point_pair_unit.sv =====
// Top level of the slice farthest point pair unit.
// Uses sfpp_pkg, sfpp_if and sfpp_cell.
//  channel | dir | payload
//  pin     | in  | x, y, z, last_point
//  pout    | out | found, indices, coordinates, distance, overflow, kept_count
// Load: one point per cycle. On last_point, the pair pass steps i,j one pair per
// cycle through a dual-read memory, then the pipeline drains, then an integer
// square root runs at one result bit per cycle, then the fetch states read the
// best pair back: S_FETCH and S_FETCH2 lead to the result.
// Reset clears control; the store needs no clearing. Input stalls while busy.
module slice_farthest_point_pair_unit import sfpp_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_D,
    parameter int COORD_BITS = COORD_BITS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    sfpp_if.sink        pin,
    sfpp_if.source      pout
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 2 * COORD_BITS + 3;
    localparam int RW = SW / 2 + 1;
    localparam logic [2:0] S_LOAD = 3'd0, S_PAIR = 3'd1, S_DRAIN = 3'd2,
                           S_SQRT = 3'd3, S_FETCH = 3'd4, S_FETCH2 = 3'd5,
                           S_OUT = 3'd6;

    logic [2:0]  r_st;
    logic signed [15:0] r_zlo, r_zhi;
    logic [3*COORD_BITS-1:0] r_mem [MAX_POINTS];
    logic [CW-1:0] r_cnt;
    logic          r_drop;
    logic [AW-1:0] r_i, r_j, r_pi, r_pj, r_bi, r_bj;
    logic          r_pv, r_done;
    logic [SW-1:0] r_best, r_rem;
    logic [RW-1:0] r_root;
    logic [5:0]    r_k;
    logic [3*COORD_BITS-1:0] r_ra, r_rb;
    logic [SW-1:0] w_s1, w_s2, w_s3;
    logic signed [COORD_BITS-1:0] w_x, w_y, w_z;
    logic w_in, w_acc;

    assign w_x = pin.data.point_x[COORD_BITS-1:0];
    assign w_y = pin.data.point_y[COORD_BITS-1:0];
    assign w_z = pin.data.point_z[COORD_BITS-1:0];
    assign w_in = (32'(signed'(w_z)) >= 32'(r_zlo)) && (32'(signed'(w_z)) <= 32'(r_zhi));
    assign pin.ready = (r_st == S_LOAD);
    assign w_acc = pin.valid && pin.ready;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_in && r_cnt < CW'(MAX_POINTS))
            r_mem[r_cnt[AW-1:0]] <= {w_x, w_y, w_z};
        r_ra <= r_mem[r_i];
        r_rb <= r_mem[r_j];
    end

    sfpp_cell #(.CB(COORD_BITS), .SW(SW)) u_cx (.i_clk(i_clk),
        .i_a(r_ra[3*COORD_BITS-1 -: COORD_BITS]), .i_b(r_rb[3*COORD_BITS-1 -: COORD_BITS]),
        .i_sum('0), .o_sum(w_s1));
    logic [3*COORD_BITS-1:0] r_ra2, r_rb2, r_ra3, r_rb3;
    sfpp_cell #(.CB(COORD_BITS), .SW(SW)) u_cy (.i_clk(i_clk),
        .i_a(r_ra2[2*COORD_BITS-1 -: COORD_BITS]), .i_b(r_rb2[2*COORD_BITS-1 -: COORD_BITS]),
        .i_sum(w_s1), .o_sum(w_s2));
    sfpp_cell #(.CB(COORD_BITS), .SW(SW)) u_cz (.i_clk(i_clk),
        .i_a(r_ra3[COORD_BITS-1:0]), .i_b(r_rb3[COORD_BITS-1:0]),
        .i_sum(w_s2), .o_sum(w_s3));

    logic [AW-1:0] r_i2, r_j2, r_i3, r_j3, r_i4, r_j4;
    logic          r_v1, r_v2, r_v3;

    logic [2*RW+1:0] w_trial;
    assign w_trial = {({1'b0, r_root} << 2) | (2*RW+2)'(1)} ;

    always_ff @(posedge i_clk) begin
        r_ra2 <= r_ra; r_rb2 <= r_rb; r_ra3 <= r_ra2; r_rb3 <= r_rb2;
        r_i2 <= r_pi; r_j2 <= r_pj; r_i3 <= r_i2; r_j3 <= r_j2;
        r_i4 <= r_i3; r_j4 <= r_j3;
        r_pi <= r_i; r_pj <= r_j;
        if (!i_rst_n) begin
            r_st <= S_LOAD; r_zlo <= Z_LOW_RST; r_zhi <= Z_HIGH_RST;
            r_cnt <= '0; r_drop <= 1'b0; pout.valid <= 1'b0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_pv <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_Z_LOW) r_zlo <= i_cfg_data;
                else r_zhi <= i_cfg_data;
            end
            r_pv <= (r_st == S_PAIR) && !r_done;
            r_v1 <= r_pv; r_v2 <= r_v1; r_v3 <= r_v2;
            if (r_v3 && w_s3 > r_best) begin
                r_best <= w_s3; r_bi <= r_i4; r_bj <= r_j4;
            end
            case (r_st)
                S_LOAD: if (w_acc) begin
                    if (w_in) begin
                        if (r_cnt < CW'(MAX_POINTS)) r_cnt <= r_cnt + 1'b1;
                        else r_drop <= 1'b1;
                    end
                    if (pin.data.last_point) begin
                        r_st <= S_PAIR; r_i <= '0; r_j <= AW'(1);
                        r_best <= '0; r_bi <= '0; r_bj <= '0;
                        r_done <= !((w_in && r_cnt < CW'(MAX_POINTS)) ? r_cnt >= CW'(1)
                                                                     : r_cnt >= CW'(2));
                    end
                end
                S_PAIR: begin
                    if (r_done) begin
                        r_st <= S_DRAIN; r_k <= '0;
                    end else if (CW'(r_j) + 1'b1 < r_cnt) begin
                        r_j <= r_j + 1'b1;
                    end else if (CW'(r_i) + 2 < r_cnt) begin
                        r_i <= r_i + 1'b1; r_j <= r_i + AW'(2);
                    end else begin
                        r_done <= 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_k == 6'd5) begin
                        r_st <= S_SQRT; r_k <= '0; r_rem <= r_best; r_root <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SQRT: begin
                    if ({2'b0, r_rem >> (2 * (RW - 1 - int'(r_k)))} >=
                        (SW+2)'(w_trial)) begin
                        r_rem <= r_rem - SW'(w_trial << (2 * (RW - 1 - int'(r_k))));
                        r_root <= (r_root << 1) | RW'(1);
                    end else begin
                        r_root <= r_root << 1;
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == 6'(RW - 1)) begin
                        r_st <= S_FETCH; r_i <= r_bi; r_j <= r_bj;
                    end
                end
                S_FETCH: r_st <= S_FETCH2;
                S_FETCH2: begin
                    r_st <= S_OUT; pout.valid <= 1'b1;
                    pout.data.found <= r_best != '0;
                    pout.data.first_index <= 10'(r_bi);
                    pout.data.second_index <= 10'(r_bj);
                    pout.data.first_x <= (r_best != '0) ? 16'(signed'(r_ra[3*COORD_BITS-1 -: COORD_BITS])) : '0;
                    pout.data.first_y <= (r_best != '0) ? 16'(signed'(r_ra[2*COORD_BITS-1 -: COORD_BITS])) : '0;
                    pout.data.first_z <= (r_best != '0) ? 16'(signed'(r_ra[COORD_BITS-1:0])) : '0;
                    pout.data.second_x <= (r_best != '0) ? 16'(signed'(r_rb[3*COORD_BITS-1 -: COORD_BITS])) : '0;
                    pout.data.second_y <= (r_best != '0) ? 16'(signed'(r_rb[2*COORD_BITS-1 -: COORD_BITS])) : '0;
                    pout.data.second_z <= (r_best != '0) ? 16'(signed'(r_rb[COORD_BITS-1:0])) : '0;
                    pout.data.distance <= 17'(r_root);
                    pout.data.overflow <= r_drop;
                    pout.data.kept_count <= 11'(r_cnt);
                end
                S_OUT: if (pout.ready) begin
                    pout.valid <= 1'b0; r_st <= S_LOAD; r_cnt <= '0; r_drop <= 1'b0;
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTH
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pout.valid |-> !pin.ready) else $error("input open while result pending");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_POINTS)) else $error("count beyond depth");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pout.valid && !pout.ready |=> pout.valid) else $error("result dropped");
`endif
endmodule

// ===== sim/tb_slice_farthest_point_pair_unit.sv =====
// Testbench for slice_farthest_point_pair_unit: directed table, then random clouds.
// Results are compared whole against an in-bench model of the pair search or a typed row.
// Depends on sfpp_pkg, sfpp_if and the unit itself.
module tb_slice_farthest_point_pair_unit;
    import sfpp_pkg::*;

    typedef enum int {ROW_POINT, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_point    pt;
        bit        typed;
        t_pair     res;
    } t_row;

    localparam int DEPTH = 1024;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [15:0] i_cfg_data;

    sfpp_if #(.t_payload(t_point)) pin_if ();
    sfpp_if #(.t_payload(t_pair)) pout_if ();

    slice_farthest_point_pair_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .pin        (pin_if.sink),
        .pout       (pout_if.source)
    );

    logic signed [15:0] slice_x [DEPTH];
    logic signed [15:0] slice_y [DEPTH];
    logic signed [15:0] slice_z [DEPTH];
    int unsigned        slice_count;
    bit                 slice_dropped;
    logic signed [15:0] band_low;
    logic signed [15:0] band_high;

    t_pair pending_pairs[$];
    t_row  rows[$];
    int    mismatches;
    int    results_seen;
    int    clouds_sent;
    int    points_sent;
    bit    ready_hold;
    bit    overflow_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("Timeout waiting for results");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [16:0] floor_root(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root[16:0];
    endfunction

    function automatic logic [63:0] sq_axis(logic signed [15:0] a, logic signed [15:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return d * d;
    endfunction

    function automatic bit search_pair(t_point p, output t_pair r);
        logic [63:0] best;
        logic [63:0] d;
        int unsigned bi;
        int unsigned bj;
        r = '0;
        if (p.point_z >= band_low && p.point_z <= band_high) begin
            if (slice_count < DEPTH) begin
                slice_x[slice_count] = p.point_x;
                slice_y[slice_count] = p.point_y;
                slice_z[slice_count] = p.point_z;
                slice_count++;
            end else begin
                slice_dropped = 1'b1;
            end
        end
        if (!p.last_point) return 1'b0;
        best = 0;
        bi = 0;
        bj = 0;
        for (int unsigned i = 0; i + 1 < slice_count; i++) begin
            for (int unsigned j = i + 1; j < slice_count; j++) begin
                d = sq_axis(slice_x[i], slice_x[j]) + sq_axis(slice_y[i], slice_y[j])
                  + sq_axis(slice_z[i], slice_z[j]);
                if (d > best) begin
                    best = d;
                    bi = i;
                    bj = j;
                end
            end
        end
        if (best != 0) begin
            r.found = 1'b1;
            r.first_index = bi[9:0];
            r.second_index = bj[9:0];
            r.first_x = slice_x[bi];
            r.first_y = slice_y[bi];
            r.first_z = slice_z[bi];
            r.second_x = slice_x[bj];
            r.second_y = slice_y[bj];
            r.second_z = slice_z[bj];
            r.distance = floor_root(best);
        end
        r.overflow = slice_dropped;
        r.kept_count = slice_count[10:0];
        slice_count = 0;
        slice_dropped = 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_point(t_point p, bit typed, t_pair typed_res);
        t_pair r;
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            pin_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pin_if.valid <= 1'b1;
        pin_if.data <= p;
        @(posedge i_clk);
        while (!pin_if.ready) @(posedge i_clk);
        points_sent++;
        if (search_pair(p, r)) begin
            pending_pairs.push_back(typed ? typed_res : r);
            clouds_sent++;
        end
    endtask

    task automatic drain();
        pin_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic set_band(logic signed [15:0] lo, logic signed [15:0] hi);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_Z_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx <= CFG_Z_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        band_low = lo;
        band_high = hi;
    endtask

    task automatic add_row(t_row_kind k, int x, int y, int z, bit last);
        t_row row;
        row.kind = k;
        row.pt = '{point_x: x[15:0], point_y: y[15:0], point_z: z[15:0], last_point: last};
        row.typed = 1'b0;
        row.res = '0;
        rows.push_back(row);
    endtask

    task automatic add_typed(int x, int y, int z, int kept);
        t_row row;
        row.kind = ROW_POINT;
        row.pt = '{point_x: x[15:0], point_y: y[15:0], point_z: z[15:0], last_point: 1'b1};
        row.typed = 1'b1;
        row.res = '0;
        row.res.kept_count = kept[10:0];
        rows.push_back(row);
    endtask

    function automatic logic signed [15:0] rand_coord(int spread);
        if (spread == 0) return 16'($urandom());
        return 16'(int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic send_cloud(int npts, int spread, int in_band_pct);
        t_point p;
        t_pair none;
        none = '0;
        for (int k = 0; k < npts; k++) begin
            p.point_x = rand_coord(spread);
            p.point_y = rand_coord(spread);
            if ($urandom_range(0, 99) < in_band_pct && band_low <= band_high)
                p.point_z = 16'(int'($urandom_range(0, int'(band_high) - int'(band_low)))
                                + int'(band_low));
            else
                p.point_z = 16'($urandom());
            p.last_point = (k == npts - 1) || ($urandom_range(0, 99) == 0);
            send_point(p, 1'b0, none);
        end
    endtask

    always @(posedge i_clk) begin
        t_pair want;
        int stall;
        if (!i_rst_n) begin
            pout_if.ready <= 1'b0;
        end else begin
            if (pout_if.valid && pout_if.ready) begin
                results_seen++;
                if (pout_if.data.overflow) overflow_seen = 1'b1;
                if (pending_pairs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result %p", pout_if.data);
                end else begin
                    want = pending_pairs.pop_front();
                    if (pout_if.data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch on result %0d:\n  expected %p\n  actual   %p",
                                     results_seen, want, pout_if.data);
                    end
                end
            end
            if (ready_hold) begin
                pout_if.ready <= 1'b1;
            end else begin
                stall = pick_gap();
                pout_if.ready <= (stall == 0) || ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial begin
        t_pair none;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_Z_LOW;
        i_cfg_data = '0;
        pin_if.valid = 1'b0;
        pin_if.data = '0;
        mismatches = 0;
        results_seen = 0;
        clouds_sent = 0;
        points_sent = 0;
        ready_hold = 1'b0;
        overflow_seen = 1'b0;
        slice_count = 0;
        slice_dropped = 1'b0;
        band_low = Z_LOW_RST;
        band_high = Z_HIGH_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_typed(0, 0, 0, 0);
        add_row(ROW_POINT, 0, 0, 500, 1'b0);
        add_row(ROW_POINT, 0, 0, 520, 1'b1);
        add_row(ROW_POINT, 5, 5, 499, 1'b0);
        add_row(ROW_POINT, 5, 5, 521, 1'b0);
        add_row(ROW_POINT, -32768, -32768, 500, 1'b0);
        add_row(ROW_POINT, 32767, 32767, 520, 1'b1);
        add_row(ROW_POINT, 7, -7, 510, 1'b0);
        add_row(ROW_POINT, 7, -7, 510, 1'b0);
        add_typed(7, -7, 510, 3);
        add_row(ROW_POINT, 1, 0, 510, 1'b0);
        add_row(ROW_POINT, 0, 1, 510, 1'b0);
        add_row(ROW_POINT, -1, 0, 510, 1'b1);
        add_row(ROW_CFG, -32768, 32767, 0, 1'b0);
        add_row(ROW_POINT, -32768, -32768, -32768, 1'b0);
        add_row(ROW_POINT, 32767, 32767, 32767, 1'b1);
        add_row(ROW_POINT, 32767, -32768, 0, 1'b1);
        add_row(ROW_CFG, 32767, -32768, 0, 1'b0);
        add_row(ROW_POINT, 1, 2, 0, 1'b0);
        add_typed(3, 4, 32767, 0);
        add_row(ROW_CFG, 100, 100, 0, 1'b0);
        add_row(ROW_POINT, -3, 9, 100, 1'b0);
        add_row(ROW_POINT, 4, -9, 100, 1'b1);

        foreach (rows[n]) begin
            if (rows[n].kind == ROW_CFG)
                set_band(rows[n].pt.point_x, rows[n].pt.point_y);
            else
                send_point(rows[n].pt, rows[n].typed, rows[n].res);
        end

        set_band(Z_LOW_RST, Z_HIGH_RST);
        for (int c = 0; c < 70; c++) begin
            if (c % 10 == 0) begin
                case ((c / 10) % 5)
                    0: set_band(-32768, 32767);
                    1: set_band(-200, 300);
                    2: set_band(16'($urandom()), 16'($urandom()));
                    3: set_band(32767, 32767);
                    default: set_band(-32768, -32768);
                endcase
            end
            if (c == 35) begin
                ready_hold = 1'b1;
                drain();
                ready_hold = 1'b0;
            end
            send_cloud($urandom_range(1, 14), ($urandom_range(0, 2) == 0) ? 0 :
                       ($urandom_range(0, 1) ? 3 : 2000), 85);
        end

        set_band(-32768, 32767);
        send_cloud(40, 50, 100);

        drain();
        $display("Covered %0d points in %0d clouds, %0d results; store overflow seen: %0d",
                 points_sent, clouds_sent, results_seen, overflow_seen);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatching results", mismatches);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
